>>> design/bis_pkg.sv
// ----------------------------------------------------------------------------
// bis_pkg
// Shared constants, types and codes of the bilinear image scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package bis_pkg;

    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;
    localparam int FRAC_BITS  = 8;

    localparam int COORD_W    = 9;
    localparam int SIZE_W     = 10;
    localparam int CC_W       = 2;
    localparam int STEP_W     = 25;
    localparam int STEP_FRAC  = 16;
    localparam int PIX_W      = 8;
    localparam int CH_NUM     = 3;
    localparam int WORD_W     = PIX_W * CH_NUM;

    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int ADDR_W     = COL_W + ROW_W;

    localparam int PROD_W     = COORD_W + STEP_W;
    localparam int IP_W       = PROD_W - STEP_FRAC;
    localparam int WT1_W      = FRAC_BITS + 1;
    localparam int WT_W       = 2 * FRAC_BITS + 1;
    localparam int ACC_W      = PIX_W + WT_W;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = STEP_W;

    localparam logic [CFG_ADDR_W-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CHANNELS   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_X_STEP     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_Y_STEP     = 3'd4;

    localparam logic [CC_W-1:0] CC_GRAY  = 2'd1;
    localparam logic [CC_W-1:0] CC_COLOR = 2'd3;

    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_COMPUTE = 1'b1;

    typedef logic [PIX_W-1:0] pixel_t;

    typedef struct packed {
        logic clear;
        logic issue;
        logic tap_x;
        logic tap_y;
    } blend_ctrl_t;

endpackage

`default_nettype wire

>>> design/bis_axis_map.sv
// ----------------------------------------------------------------------------
// bis_axis_map
// Maps one destination coordinate into the source: multiply by the step,
// then clamp to the last index and split into neighbours and fraction.
// ----------------------------------------------------------------------------
`default_nettype none

module bis_axis_map
    import bis_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 mul_en,
    input  wire logic                 clamp_en,
    input  wire logic [COORD_W-1:0]   coord,
    input  wire logic [STEP_W-1:0]    step,
    input  wire logic [COORD_W-1:0]   last,
    output logic      [COORD_W-1:0]   lo,
    output logic      [COORD_W-1:0]   hi,
    output logic      [FRAC_BITS-1:0] frac
);

    logic [PROD_W-1:0]    prod_reg;
    logic [COORD_W-1:0]   lo_reg;
    logic [COORD_W-1:0]   hi_reg;
    logic [FRAC_BITS-1:0] frac_reg;
    logic [IP_W-1:0]      ip;
    logic                 sat;

    assign ip  = prod_reg[PROD_W-1:STEP_FRAC];
    assign sat = ip >= IP_W'(last);

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= PROD_W'(coord) * PROD_W'(step);
        end
        if (clamp_en)
        begin
            lo_reg   <= sat ? last : ip[COORD_W-1:0];
            hi_reg   <= sat ? last : ip[COORD_W-1:0] + COORD_W'(1);
            frac_reg <= sat ? '0 : prod_reg[STEP_FRAC-1:STEP_FRAC-FRAC_BITS];
        end
    end

    assign lo   = lo_reg;
    assign hi   = hi_reg;
    assign frac = frac_reg;

endmodule

`default_nettype wire

>>> design/bis_frame_mem.sv
// ----------------------------------------------------------------------------
// bis_frame_mem
// Single-port source frame store with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bis_frame_mem
    import bis_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [WORD_W-1:0] wr_data,
    output logic      [WORD_W-1:0] rd_data
);

    logic [WORD_W-1:0] mem [2**ADDR_W];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        rd_data_reg <= mem[addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> design/bis_blend.sv
// ----------------------------------------------------------------------------
// bis_blend
// Weights each neighbour read from the frame store and accumulates the
// three channel sums over the four taps.
// ----------------------------------------------------------------------------
`default_nettype none

module bis_blend
    import bis_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire blend_ctrl_t          ctrl,
    input  wire logic [FRAC_BITS-1:0] fx,
    input  wire logic [FRAC_BITS-1:0] fy,
    input  wire logic [WORD_W-1:0]    rd_data,
    output pixel_t                    sum_c [CH_NUM]
);

    localparam logic [WT1_W-1:0] ONE = WT1_W'(1) << FRAC_BITS;

    logic [WT1_W-1:0] wx;
    logic [WT1_W-1:0] wy;
    logic [WT_W-1:0]  weight_reg;
    logic             tap_valid_reg;
    logic             prod_valid_reg;
    logic [ACC_W-1:0] prod_reg [CH_NUM];
    logic [ACC_W-1:0] acc_reg  [CH_NUM];

    assign wx = ctrl.tap_x ? WT1_W'(fx) : ONE - WT1_W'(fx);
    assign wy = ctrl.tap_y ? WT1_W'(fy) : ONE - WT1_W'(fy);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            tap_valid_reg  <= ctrl.issue;
            prod_valid_reg <= tap_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.issue)
        begin
            weight_reg <= WT_W'(wx) * WT_W'(wy);
        end
        for (int c = 0; c < CH_NUM; c++)
        begin
            if (tap_valid_reg)
            begin
                prod_reg[c] <= ACC_W'(rd_data[c*PIX_W +: PIX_W]) * ACC_W'(weight_reg);
            end
            if (ctrl.clear)
            begin
                acc_reg[c] <= '0;
            end
            else if (prod_valid_reg)
            begin
                acc_reg[c] <= acc_reg[c] + prod_reg[c];
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < CH_NUM; c++)
        begin
            sum_c[c] = acc_reg[c][2*FRAC_BITS +: PIX_W];
        end
    end

endmodule

`default_nettype wire

>>> design/bilinear_image_scaler.sv
// ----------------------------------------------------------------------------
// bilinear_image_scaler
// Source frame store with bilinear resampling of destination pixels.
// ----------------------------------------------------------------------------
// A load transaction (mode 0) writes one source pixel and leaves the input
// ready. A compute transaction (mode 1) does the step multiply at the
// accepting edge, then clamps, reads the four neighbours one by one from the
// single-port frame memory, weights and accumulates them during the reads and
// the flush, and loads the output register once the last result is taken.
// The input is held off from the clamp until that load, so each compute
// transaction finishes before another is taken. The next transaction is
// accepted once that result sits in the output register, even if it has not
// been taken yet. A compute transaction with a channel count other than one
// or three is accepted and produces no result. The frame memory is not
// cleared; only loaded pixels may be referenced.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_image_scaler
    import bis_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  mode,
    input  wire logic [COORD_W-1:0]    col,
    input  wire logic [COORD_W-1:0]    row,
    input  wire logic [PIX_W-1:0]      pix_c0,
    input  wire logic [PIX_W-1:0]      pix_c1,
    input  wire logic [PIX_W-1:0]      pix_c2,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic      [PIX_W-1:0]      out_c0,
    output logic      [PIX_W-1:0]      out_c1,
    output logic      [PIX_W-1:0]      out_c2
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CLAMP  = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_FLUSH  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    localparam logic [1:0] LAST_TAP   = 2'd3;
    localparam logic [1:0] LAST_FLUSH = 2'd1;

    logic [2:0]          state_reg, state_next;
    logic [1:0]          cnt_reg, cnt_next;
    logic [COORD_W-1:0]  last_x_reg, last_y_reg;
    logic [CC_W-1:0]     channels_reg;
    logic [STEP_W-1:0]   x_step_reg, y_step_reg;
    logic                gray_reg;
    logic                out_valid_reg, out_valid_next;
    pixel_t              out_c0_reg, out_c1_reg, out_c2_reg;

    logic                accept;
    logic                accept_compute;
    logic                color_ok;
    logic                out_load;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_addr;
    logic [WORD_W-1:0]   mem_rdata;
    logic [COORD_W-1:0]  x0, x1, y0, y1;
    logic [COORD_W-1:0]  tap_col, tap_row;
    logic [FRAC_BITS-1:0] fx, fy;
    blend_ctrl_t         bctrl;
    pixel_t              sum_c [CH_NUM];

    function automatic logic [COORD_W-1:0] last_index(input logic [SIZE_W-1:0] size,
                                                      input logic [SIZE_W-1:0] limit);
        logic [SIZE_W-1:0] res;
        if (size == '0)
        begin
            res = '0;
        end
        else if (size > limit)
        begin
            res = limit - SIZE_W'(1);
        end
        else
        begin
            res = size - SIZE_W'(1);
        end
        return res[COORD_W-1:0];
    endfunction

    assign in_ready       = (state_reg == ST_IDLE);
    assign accept         = in_valid && in_ready;
    assign color_ok       = (channels_reg == CC_GRAY) || (channels_reg == CC_COLOR);
    assign accept_compute = accept && (mode == MODE_COMPUTE) && color_ok;
    assign mem_we         = accept && (mode == MODE_LOAD);
    assign out_load       = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_x_reg   <= COORD_W'(MAX_WIDTH - 1);
            last_y_reg   <= COORD_W'(MAX_HEIGHT - 1);
            channels_reg <= CC_GRAY;
            x_step_reg   <= STEP_W'(1) << STEP_FRAC;
            y_step_reg   <= STEP_W'(1) << STEP_FRAC;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_SRC_WIDTH:
                    last_x_reg <= last_index(cfg_wr_data[SIZE_W-1:0], SIZE_W'(MAX_WIDTH));
                REG_SRC_HEIGHT:
                    last_y_reg <= last_index(cfg_wr_data[SIZE_W-1:0], SIZE_W'(MAX_HEIGHT));
                REG_CHANNELS:
                    channels_reg <= cfg_wr_data[CC_W-1:0];
                REG_X_STEP:
                    x_step_reg <= cfg_wr_data[STEP_W-1:0];
                REG_Y_STEP:
                    y_step_reg <= cfg_wr_data[STEP_W-1:0];
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_compute)
                begin
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP:
            begin
                state_next = ST_READ;
                cnt_next   = '0;
            end
            ST_READ:
            begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == LAST_TAP)
                begin
                    state_next = ST_FLUSH;
                    cnt_next   = '0;
                end
            end
            ST_FLUSH:
            begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == LAST_FLUSH)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_compute)
        begin
            gray_reg <= (channels_reg == CC_GRAY);
        end
        if (out_load)
        begin
            out_c0_reg <= sum_c[0];
            out_c1_reg <= gray_reg ? '0 : sum_c[1];
            out_c2_reg <= gray_reg ? '0 : sum_c[2];
        end
    end

    bis_axis_map u_map_x (
        .clk      (clk),
        .mul_en   (accept_compute),
        .clamp_en (state_reg == ST_CLAMP),
        .coord    (col),
        .step     (x_step_reg),
        .last     (last_x_reg),
        .lo       (x0),
        .hi       (x1),
        .frac     (fx)
    );

    bis_axis_map u_map_y (
        .clk      (clk),
        .mul_en   (accept_compute),
        .clamp_en (state_reg == ST_CLAMP),
        .coord    (row),
        .step     (y_step_reg),
        .last     (last_y_reg),
        .lo       (y0),
        .hi       (y1),
        .frac     (fy)
    );

    assign tap_col = cnt_reg[0] ? x1 : x0;
    assign tap_row = cnt_reg[1] ? y1 : y0;

    always_comb
    begin
        if (state_reg == ST_READ)
        begin
            mem_addr = {tap_row[ROW_W-1:0], tap_col[COL_W-1:0]};
        end
        else
        begin
            mem_addr = {row[ROW_W-1:0], col[COL_W-1:0]};
        end
    end

    bis_frame_mem u_frame (
        .clk     (clk),
        .wr_en   (mem_we),
        .addr    (mem_addr),
        .wr_data ({pix_c2, pix_c1, pix_c0}),
        .rd_data (mem_rdata)
    );

    assign bctrl.clear = (state_reg == ST_CLAMP);
    assign bctrl.issue = (state_reg == ST_READ);
    assign bctrl.tap_x = cnt_reg[0];
    assign bctrl.tap_y = cnt_reg[1];

    bis_blend u_blend (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (bctrl),
        .fx      (fx),
        .fy      (fy),
        .rd_data (mem_rdata),
        .sum_c   (sum_c)
    );

    assign out_valid = out_valid_reg;
    assign out_c0    = out_c0_reg;
    assign out_c1    = out_c1_reg;
    assign out_c2    = out_c2_reg;

    // A frame write only happens while no compute transaction is reading.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_IDLE))
        else $error("frame write during a compute transaction");

    // Every neighbour read stays inside the configured frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (tap_col <= last_x_reg) && (tap_row <= last_y_reg))
        else $error("neighbour read outside the source frame");

    // A finished result always lands in the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg && (state_reg == ST_IDLE))
        else $error("finished result not presented");

    // The accumulation flush is only entered straight from the neighbour reads.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH) && (cnt_reg == '0) |-> $past(state_reg == ST_READ))
        else $error("flush entered without completing the reads");

endmodule

`default_nettype wire

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench of the bilinear image scaler. A behavioral predictor keeps its own
// copy of the source frame and the registers and works out each interpolated
// pixel when its compute transaction is accepted. A checker compares every
// result with the oldest prediction. Directed cases cover the register
// extremes, both modes and the edge clamping. Random phases under changing
// idle patterns follow, and a long output stall closes the run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import bis_pkg::*;

    localparam int          CYCLE_LIMIT = 400000;
    localparam int          DRAIN_CYCLES = 20;
    localparam int          HOLD_CYCLES = 300;
    localparam int          PHASE_ITEMS = 90;
    localparam int          PHASES_PER_RUN = 3;
    localparam logic [CC_W-1:0] CC_NONE = 2'd0;
    localparam logic [CC_W-1:0] CC_PAIR = 2'd2;

    typedef struct packed {
        pixel_t c2;
        pixel_t c1;
        pixel_t c0;
    } rgb_pixel_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  mode = MODE_LOAD;
    logic [COORD_W-1:0]    col = '0;
    logic [COORD_W-1:0]    row = '0;
    logic [PIX_W-1:0]      pix_c0 = '0;
    logic [PIX_W-1:0]      pix_c1 = '0;
    logic [PIX_W-1:0]      pix_c2 = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [PIX_W-1:0]      out_c0;
    logic [PIX_W-1:0]      out_c1;
    logic [PIX_W-1:0]      out_c2;

    logic [SIZE_W-1:0]     scaler_width = 10'd512;
    logic [SIZE_W-1:0]     scaler_height = 10'd512;
    logic [CC_W-1:0]       scaler_channels = CC_GRAY;
    logic [STEP_W-1:0]     scaler_x_step = 25'd65536;
    logic [STEP_W-1:0]     scaler_y_step = 25'd65536;
    logic [WORD_W-1:0]     frame_mem [int unsigned];
    rgb_pixel_t            expected_pixels [$];

    int                    send_idle_pct = 0;
    int                    recv_idle_pct = 0;
    bit                    hold_request = 1'b0;
    int                    mismatch_count = 0;
    int unsigned           cycle_count = 0;

    bilinear_image_scaler u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .col         (col),
        .row         (row),
        .pix_c0      (pix_c0),
        .pix_c1      (pix_c1),
        .pix_c2      (pix_c2),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_c0      (out_c0),
        .out_c1      (out_c1),
        .out_c2      (out_c2)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** bilinear_image_scaler: FAILED **");
            $finish;
        end
    end

    function automatic int unsigned last_index(input int size, input int limit);
        int s;
        s = size;
        if (s < 1)
            s = 1;
        if (s > limit)
            s = limit;
        return s - 1;
    endfunction

    function automatic void map_axis(input logic [COORD_W-1:0] coord,
                                     input logic [STEP_W-1:0] step,
                                     input int unsigned last,
                                     output int unsigned lo, output int unsigned hi,
                                     output int unsigned frac);
        longint unsigned pos;
        longint unsigned ip;
        pos = coord;
        pos = (pos * step) >> (STEP_FRAC - FRAC_BITS);
        ip = pos >> FRAC_BITS;
        frac = 32'(pos & ((64'd1 << FRAC_BITS) - 1));
        if (ip >= last)
        begin
            ip = last;
            frac = 0;
        end
        lo = 32'(ip);
        hi = (lo + 1 > last) ? last : lo + 1;
    endfunction

    function automatic int unsigned frame_key(input int unsigned x, input int unsigned y);
        return y * MAX_WIDTH + x;
    endfunction

    function automatic logic [WORD_W-1:0] frame_word(input int unsigned x, input int unsigned y);
        if (frame_mem.exists(frame_key(x, y)))
            return frame_mem[frame_key(x, y)];
        return '0;
    endfunction

    function automatic bit neighbors_loaded(input logic [COORD_W-1:0] c,
                                            input logic [COORD_W-1:0] r);
        int unsigned x0, x1, y0, y1, fx, fy;
        map_axis(c, scaler_x_step, last_index(scaler_width, MAX_WIDTH), x0, x1, fx);
        map_axis(r, scaler_y_step, last_index(scaler_height, MAX_HEIGHT), y0, y1, fy);
        return frame_mem.exists(frame_key(x0, y0)) && frame_mem.exists(frame_key(x1, y0))
            && frame_mem.exists(frame_key(x0, y1)) && frame_mem.exists(frame_key(x1, y1));
    endfunction

    function automatic bit interpolate_pixel(input logic [COORD_W-1:0] c,
                                             input logic [COORD_W-1:0] r,
                                             output rgb_pixel_t px);
        int unsigned       x0, x1, y0, y1, fx, fy;
        longint unsigned   one, w00, w01, w10, w11, acc;
        logic [WORD_W-1:0] p00, p01, p10, p11;
        pixel_t            chan [CH_NUM];
        int                ch;
        px = '0;
        if (scaler_channels != CC_GRAY && scaler_channels != CC_COLOR)
            return 1'b0;
        map_axis(c, scaler_x_step, last_index(scaler_width, MAX_WIDTH), x0, x1, fx);
        map_axis(r, scaler_y_step, last_index(scaler_height, MAX_HEIGHT), y0, y1, fy);
        one = 64'd1 << FRAC_BITS;
        w00 = (one - fx) * (one - fy);
        w01 = fx * (one - fy);
        w10 = (one - fx) * fy;
        w11 = fx * fy;
        p00 = frame_word(x0, y0);
        p01 = frame_word(x1, y0);
        p10 = frame_word(x0, y1);
        p11 = frame_word(x1, y1);
        for (ch = 0; ch < CH_NUM; ch++)
        begin
            acc = p00[ch*PIX_W +: PIX_W] * w00 + p01[ch*PIX_W +: PIX_W] * w01
                + p10[ch*PIX_W +: PIX_W] * w10 + p11[ch*PIX_W +: PIX_W] * w11;
            chan[ch] = (scaler_channels == CC_GRAY && ch > 0) ? '0
                     : pixel_t'(acc >> (2 * FRAC_BITS));
        end
        px.c0 = chan[0];
        px.c1 = chan[1];
        px.c2 = chan[2];
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        rgb_pixel_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_pixels.size() == 0)
                report_mismatch("unexpected result transaction", out_c0, -1);
            else
            begin
                want = expected_pixels.pop_front();
                if (out_c0 !== want.c0)
                    report_mismatch("out_c0", out_c0, want.c0);
                if (out_c1 !== want.c1)
                    report_mismatch("out_c1", out_c1, want.c1);
                if (out_c2 !== want.c2)
                    report_mismatch("out_c2", out_c2, want.c2);
            end
        end
    end

    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    task automatic send_item(input logic m, input logic [COORD_W-1:0] c,
                             input logic [COORD_W-1:0] r,
                             input pixel_t p0, input pixel_t p1, input pixel_t p2);
        rgb_pixel_t px;
        @(negedge clk);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        col <= c;
        row <= r;
        pix_c0 <= p0;
        pix_c1 <= p1;
        pix_c2 <= p2;
        do
            @(posedge clk);
        while (!in_ready);
        if (m == MODE_LOAD)
            frame_mem[frame_key(c, r)] = {p2, p1, p0};
        else if (interpolate_pixel(c, r, px))
            expected_pixels.push_back(px);
    endtask

    task automatic load_pixel(input int c, input int r, input logic [WORD_W-1:0] rgb);
        send_item(MODE_LOAD, COORD_W'(c), COORD_W'(r), rgb[7:0], rgb[15:8], rgb[23:16]);
    endtask

    task automatic compute_at(input int c, input int r);
        send_item(MODE_COMPUTE, COORD_W'(c), COORD_W'(r),
                  PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom));
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= data;
    endtask

    // Narrow registers get random upper bits, which the block must drop.
    task automatic set_config(input int w, input int h, input logic [CC_W-1:0] cc,
                              input logic [STEP_W-1:0] xs, input logic [STEP_W-1:0] ys);
        logic [CFG_DATA_W-1:0] data;
        wait_idle();
        data = CFG_DATA_W'($urandom);
        data[SIZE_W-1:0] = SIZE_W'(w);
        write_reg(REG_SRC_WIDTH, data);
        data = CFG_DATA_W'($urandom);
        data[SIZE_W-1:0] = SIZE_W'(h);
        write_reg(REG_SRC_HEIGHT, data);
        data = CFG_DATA_W'($urandom);
        data[CC_W-1:0] = cc;
        write_reg(REG_CHANNELS, data);
        write_reg(REG_X_STEP, xs);
        write_reg(REG_Y_STEP, ys);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        scaler_width = SIZE_W'(w);
        scaler_height = SIZE_W'(h);
        scaler_channels = cc;
        scaler_x_step = xs;
        scaler_y_step = ys;
    endtask

    function automatic int random_size();
        case ($urandom_range(9, 0))
            0: return $urandom_range(1, 0);
            1: return $urandom_range(1023, 513);
            2: return MAX_WIDTH;
            default: return $urandom_range(12, 2);
        endcase
    endfunction

    function automatic logic [STEP_W-1:0] random_step();
        if ($urandom_range(9, 0) == 0)
            return STEP_W'($urandom);
        return STEP_W'($urandom_range(1 << 17, 0));
    endfunction

    function automatic int unsigned pick_dest(input logic [STEP_W-1:0] step);
        longint unsigned reach;
        if ($urandom_range(3, 0) == 0 || step == 0)
            return $urandom_range(511, 0);
        reach = 64'd7 << STEP_FRAC;
        reach = reach / step;
        if (reach > 511)
            reach = 511;
        return $urandom_range(32'(reach), 0);
    endfunction

    // The stored region is the low corner plus the last two lines of each axis.
    function automatic int unsigned region_coord(input int unsigned last);
        if (last <= 5 || $urandom_range(1, 0) == 0)
            return $urandom_range(last < 5 ? last : 5, 0);
        return $urandom_range(last, last - 1);
    endfunction

    task automatic preload_region();
        int unsigned lw, lh, x, y;
        lw = last_index(scaler_width, MAX_WIDTH);
        lh = last_index(scaler_height, MAX_HEIGHT);
        for (y = 0; y <= lh; y++)
        begin
            if (y <= 5 || y + 1 >= lh)
            begin
                for (x = 0; x <= lw; x++)
                begin
                    if (x <= 5 || x + 1 >= lw)
                        load_pixel(x, y, WORD_W'($urandom));
                end
            end
        end
    endtask

    task automatic compute_random();
        int unsigned c, r, tries;
        bit          found;
        found = 1'b0;
        tries = 0;
        c = 0;
        r = 0;
        while (!found && tries < 16)
        begin
            c = pick_dest(scaler_x_step);
            r = pick_dest(scaler_y_step);
            found = neighbors_loaded(COORD_W'(c), COORD_W'(r));
            tries++;
        end
        if (!found)
        begin
            c = 0;
            r = 0;
        end
        compute_at(c, r);
    endtask

    task automatic test_reset_defaults();
        int x, y;
        for (y = 0; y < 3; y++)
        begin
            for (x = 0; x < 3; x++)
            begin
                if (x == 0 && y == 0)
                    load_pixel(x, y, 24'hFFFFFF);
                else if (x == 1 && y == 0)
                    load_pixel(x, y, 24'h000000);
                else
                    load_pixel(x, y, WORD_W'($urandom));
            end
        end
        load_pixel(511, 511, WORD_W'($urandom));
        compute_at(0, 0);
        compute_at(1, 1);
        compute_at(511, 511);
    endtask

    task automatic test_half_step();
        set_config(MAX_WIDTH, MAX_HEIGHT, CC_GRAY, 25'h8000, 25'h8000);
        compute_at(1, 1);
        compute_at(3, 3);
        compute_at(1, 2);
    endtask

    task automatic test_channel_modes();
        set_config(MAX_WIDTH, MAX_HEIGHT, CC_COLOR, 25'h8000, 25'h8000);
        compute_at(3, 3);
        set_config(MAX_WIDTH, MAX_HEIGHT, CC_NONE, 25'h8000, 25'h8000);
        compute_at(1, 1);
        set_config(MAX_WIDTH, MAX_HEIGHT, CC_PAIR, 25'h8000, 25'h8000);
        compute_at(1, 1);
    endtask

    task automatic test_size_limits();
        load_pixel(0, 511, WORD_W'($urandom));
        set_config(0, 1023, CC_GRAY, 25'h0, 25'h1FFFFFF);
        compute_at(511, 1);
        compute_at(5, 0);
        set_config(3, 2, CC_COLOR, 25'h1FFFFFF, 25'h10000);
        compute_at(1, 0);
        compute_at(0, 1);
        compute_at(0, 0);
        set_config(1, 1, CC_GRAY, 25'h10000, 25'h10000);
        compute_at(2, 2);
    endtask

    task automatic test_random_phases(input int send_pct, input int recv_pct);
        int                phase, n, kind;
        logic [CC_W-1:0]   cc;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (phase = 0; phase < PHASES_PER_RUN; phase++)
        begin
            if ($urandom_range(99, 0) < 85)
                cc = $urandom_range(1, 0) ? CC_COLOR : CC_GRAY;
            else
                cc = $urandom_range(1, 0) ? CC_PAIR : CC_NONE;
            set_config(random_size(), random_size(), cc, random_step(), random_step());
            preload_region();
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                kind = $urandom_range(99, 0);
                if (kind < 60)
                    compute_random();
                else if (kind < 85)
                    load_pixel(region_coord(last_index(scaler_width, MAX_WIDTH)),
                               region_coord(last_index(scaler_height, MAX_HEIGHT)),
                               WORD_W'($urandom));
                else
                    load_pixel($urandom_range(511, 0), $urandom_range(511, 0),
                               WORD_W'($urandom));
            end
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(6, 6, CC_COLOR, 25'h8000, 25'h8000);
        preload_region();
        hold_request = 1'b1;
        repeat (40) compute_random();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 27;
        recv_idle_pct = 60;
        test_reset_defaults();
        test_half_step();
        test_channel_modes();
        test_size_limits();
        test_random_phases(27, 60);
        test_random_phases(60, 27);
        test_random_phases(0, 0);
        test_backpressure();
        wait_idle();
        if (mismatch_count == 0)
            $display("** bilinear_image_scaler: PASSED **");
        else
            $display("** bilinear_image_scaler: FAILED **");
        $finish;
    end

endmodule

>>> sim.f
design/bis_pkg.sv
design/bis_axis_map.sv
design/bis_frame_mem.sv
design/bis_blend.sv
design/bilinear_image_scaler.sv
test/tb.sv
